[rtl/pgphs_pkg.sv]
// ----------------------------------------------------------------------------
// pgphs_pkg
// Shared types and constants for the packet header scanner.
// ----------------------------------------------------------------------------
package pgphs_pkg;

  localparam int POS_BITS_DEFAULT = 32;
  localparam logic [5:0] WANTED_TAG_RESET = 6'd1;

  localparam logic [7:0] NEW_LEN_TWO_BYTE  = 8'd192;
  localparam logic [7:0] NEW_LEN_PARTIAL   = 8'd224;
  localparam logic [7:0] NEW_LEN_FIVE_BYTE = 8'hFF;

  localparam logic [1:0] OLD_LEN_ONE   = 2'd0;
  localparam logic [1:0] OLD_LEN_TWO   = 2'd1;
  localparam logic [1:0] OLD_LEN_FOUR  = 2'd2;
  localparam logic [1:0] OLD_LEN_INDET = 2'd3;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NOTFOUND  = 2'd2
  } status_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [31:0] offset;
    logic [31:0] length;
  } result_t;

endpackage

[rtl/pgp_packet_header_scanner_core.sv]
// ----------------------------------------------------------------------------
// pgp_packet_header_scanner_core
// Scans an OpenPGP byte stream for the first packet with the wanted tag.
// ----------------------------------------------------------------------------
// The core takes one byte per cycle without gaps, as long as the result side
// keeps up. A byte is held in the input register while the header state
// machine works on it, and its result, if any, is loaded into the result
// register at the same edge that retires the byte, so the result lags the byte
// by the input register and the result register. A result that waits for
// out_ready holds the next byte in the input register. The single state
// update per byte sets this rate. At most one result beat is given per
// stream: found, malformed or not found, the latter two with zero offset and
// length.
// ----------------------------------------------------------------------------
module pgp_packet_header_scanner_core #(
  parameter int POSITION_BITS = pgphs_pkg::POS_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_wanted_tag,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_payload_offset,
  output logic [31:0] out_payload_length,
  output logic [32:0] out_total_consumed
);
  import pgphs_pkg::*;

  logic [5:0]  wanted_tag_r;
  logic        in_valid_r;
  logic [7:0]  in_data_byte_r;
  logic        in_last_r;
  logic        advance;
  result_t     res;
  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_offset_r;
  logic [31:0] out_length_r;
  logic [32:0] out_total_r;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_tag_r <= WANTED_TAG_RESET;
    end else if (cfg_valid) begin
      wanted_tag_r <= cfg_wanted_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_byte_r <= in_data_byte;
      in_last_r      <= in_last;
    end
  end

  pgphs_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .data_byte  (in_data_byte_r),
    .last       (in_last_r),
    .wanted_tag (wanted_tag_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_status_r <= res.status;
      out_offset_r <= res.offset;
      out_length_r <= res.length;
      out_total_r  <= {1'b0, res.offset} + {1'b0, res.length};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_offset_r;
  assign out_payload_length = out_length_r;
  assign out_total_consumed = out_total_r;

endmodule

[rtl/pgphs_parser.sv]
// ----------------------------------------------------------------------------
// pgphs_parser
// Packet header state machine: decodes headers, skips bodies and forms one
// result per stream at most, one byte per step.
// ----------------------------------------------------------------------------
module pgphs_parser #(
  parameter int POSITION_BITS = pgphs_pkg::POS_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last,
  input  logic [5:0]          wanted_tag,
  output pgphs_pkg::result_t  res
);
  import pgphs_pkg::*;

  localparam int OffW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NEWLEN,
    PH_BYTES,
    PH_NEWLEN2,
    PH_SKIP,
    PH_DONE
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [5:0]               tag_r, tag_nxt;
  logic [2:0]               left_r, left_nxt;
  logic [4:0]               first_r, first_nxt;
  logic [31:0]              acc_r, acc_nxt;
  logic [31:0]              skip_r, skip_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     finished_r, finished_nxt;

  logic                     hdr_fire;
  logic                     fail_fire;
  logic [31:0]              hdr_len;
  logic [OffW-1:0]          off_ext;
  logic [31:0]              off32;

  always_comb begin
    pos_nxt = (pos_r == '1) ? pos_r : pos_r + 1'b1;
    off_ext = OffW'(pos_nxt);
    off32 = (off_ext > OffW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : off_ext[31:0];
  end

  always_comb begin
    phase_nxt    = phase_r;
    tag_nxt      = tag_r;
    left_nxt     = left_r;
    first_nxt    = first_r;
    acc_nxt      = acc_r;
    skip_nxt     = skip_r;
    finished_nxt = finished_r;
    hdr_fire     = 1'b0;
    fail_fire    = 1'b0;
    hdr_len      = '0;
    res          = '0;
    res.status   = ST_FOUND;

    if (!finished_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (!data_byte[7]) begin
            fail_fire = 1'b1;
          end else if (data_byte[6]) begin
            tag_nxt   = data_byte[5:0];
            phase_nxt = PH_NEWLEN;
          end else begin
            tag_nxt = {2'b00, data_byte[5:2]};
            acc_nxt = '0;
            case (data_byte[1:0])
              OLD_LEN_ONE: begin
                left_nxt  = 3'd1;
                phase_nxt = PH_BYTES;
              end
              OLD_LEN_TWO: begin
                left_nxt  = 3'd2;
                phase_nxt = PH_BYTES;
              end
              OLD_LEN_FOUR: begin
                left_nxt  = 3'd4;
                phase_nxt = PH_BYTES;
              end
              default: begin
                fail_fire = 1'b1;
              end
            endcase
          end
        end
        PH_NEWLEN: begin
          if (data_byte < NEW_LEN_TWO_BYTE) begin
            hdr_fire = 1'b1;
            hdr_len  = 32'(data_byte);
          end else if (data_byte < NEW_LEN_PARTIAL) begin
            first_nxt = data_byte[4:0];
            phase_nxt = PH_NEWLEN2;
          end else if (data_byte == NEW_LEN_FIVE_BYTE) begin
            left_nxt  = 3'd4;
            acc_nxt   = '0;
            phase_nxt = PH_BYTES;
          end else begin
            fail_fire = 1'b1;
          end
        end
        PH_NEWLEN2: begin
          hdr_fire = 1'b1;
          hdr_len  = 32'({first_r, data_byte}) + 32'(NEW_LEN_TWO_BYTE);
        end
        PH_BYTES: begin
          acc_nxt  = {acc_r[23:0], data_byte};
          left_nxt = left_r - 3'd1;
          if (left_nxt == 3'd0) begin
            hdr_fire = 1'b1;
            hdr_len  = acc_nxt;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_nxt == 32'd0) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end

    if (fail_fire) begin
      finished_nxt = 1'b1;
      phase_nxt    = PH_DONE;
      res.valid    = 1'b1;
      res.status   = ST_MALFORMED;
    end else if (hdr_fire) begin
      if (tag_r == wanted_tag) begin
        finished_nxt = 1'b1;
        phase_nxt    = PH_DONE;
        res.valid    = 1'b1;
        res.status   = ST_FOUND;
        res.offset   = off32;
        res.length   = hdr_len;
      end else begin
        skip_nxt  = hdr_len;
        phase_nxt = (hdr_len != 32'd0) ? PH_SKIP : PH_HEADER;
      end
    end

    if (last) begin
      if (!finished_nxt) begin
        res.valid  = 1'b1;
        res.status = (phase_nxt == PH_NEWLEN || phase_nxt == PH_NEWLEN2 ||
                      phase_nxt == PH_BYTES) ? ST_MALFORMED : ST_NOTFOUND;
      end
      phase_nxt    = PH_HEADER;
      tag_nxt      = '0;
      left_nxt     = '0;
      first_nxt    = '0;
      acc_nxt      = '0;
      skip_nxt     = '0;
      finished_nxt = 1'b0;
    end

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      tag_r      <= '0;
      left_r     <= '0;
      first_r    <= '0;
      acc_r      <= '0;
      skip_r     <= '0;
      pos_r      <= '0;
      finished_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tag_r      <= tag_nxt;
      left_r     <= left_nxt;
      first_r    <= first_nxt;
      acc_r      <= acc_nxt;
      skip_r     <= skip_nxt;
      pos_r      <= last ? '0 : pos_nxt;
      finished_r <= finished_nxt;
    end
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != 32'd0)
    else $error("skip phase entered with an empty body count");

  a_finished_done: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> phase_r == PH_DONE)
    else $error("finished stream is not in the done phase");

  a_result_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> step)
    else $error("result raised without a byte being processed");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> phase_r == PH_HEADER && !finished_r && pos_r == '0)
    else $error("final byte did not return the stream state to its start");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into pgp_packet_header_scanner_core and checks every
// result beat against a cycle-free scanner model kept in the testbench.
// Streams mix well-formed packet chains of both header formats with broken
// and noisy ones, under several wanted tags and several idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pgphs_pkg::*;

  typedef enum logic [2:0] {
    SC_HEADER, SC_NEWLEN, SC_BYTES, SC_NEWLEN2, SC_SKIP, SC_DONE
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [31:0] length;
    logic [32:0] total;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_wanted_tag = 6'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_payload_offset;
  logic [31:0] out_payload_length;
  logic [32:0] out_total_consumed;

  stream_beat_t byte_queue[$];
  scan_result_t pending_results[$];
  logic [7:0]   stream_buf[$];
  stream_beat_t next_beat;
  scan_result_t got_result;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          bytes_queued = 0;
  int          errors = 0;
  logic [5:0]  cur_want = WANTED_TAG_RESET;

  scan_phase_t scan_phase;
  logic [5:0]  model_tag;
  logic [5:0]  cur_tag;
  logic [2:0]  len_left;
  logic [7:0]  first_len;
  logic [31:0] len_acc;
  logic [31:0] skip_left;
  logic [31:0] byte_pos;
  logic        done_flag;

  pgp_packet_header_scanner_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_wanted_tag     (cfg_wanted_tag),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_total_consumed (out_total_consumed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void clear_scan();
    scan_phase = SC_HEADER;
    cur_tag = 6'd0;
    len_left = 3'd0;
    first_len = 8'd0;
    len_acc = 32'd0;
    skip_left = 32'd0;
    byte_pos = 32'd0;
    done_flag = 1'b0;
  endfunction

  function automatic void push_status(input status_t st);
    scan_result_t r;
    r.status = st;
    r.offset = 32'd0;
    r.length = 32'd0;
    r.total = 33'd0;
    pending_results.push_back(r);
  endfunction

  function automatic logic scan_fail();
    done_flag = 1'b1;
    scan_phase = SC_DONE;
    push_status(ST_MALFORMED);
    return 1'b1;
  endfunction

  function automatic logic header_end(input logic [31:0] len);
    logic [31:0]  off;
    scan_result_t r;
    off = (byte_pos == 32'hFFFF_FFFF) ? byte_pos : byte_pos + 32'd1;
    if (cur_tag == model_tag) begin
      done_flag = 1'b1;
      scan_phase = SC_DONE;
      r.status = ST_FOUND;
      r.offset = off;
      r.length = len;
      r.total = {1'b0, off} + {1'b0, len};
      pending_results.push_back(r);
      return 1'b1;
    end
    skip_left = len;
    scan_phase = (len != 32'd0) ? SC_SKIP : SC_HEADER;
    return 1'b0;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic lst);
    logic hit;
    hit = 1'b0;
    if (!done_flag) begin
      case (scan_phase)
        SC_HEADER: begin
          if (!b[7]) begin
            hit = scan_fail();
          end else if (b[6]) begin
            cur_tag = b[5:0];
            scan_phase = SC_NEWLEN;
          end else begin
            cur_tag = {2'b00, b[5:2]};
            if (b[1:0] == OLD_LEN_INDET) begin
              hit = scan_fail();
            end else begin
              len_left = (b[1:0] == OLD_LEN_ONE) ? 3'd1 :
                         (b[1:0] == OLD_LEN_TWO) ? 3'd2 : 3'd4;
              len_acc = 32'd0;
              scan_phase = SC_BYTES;
            end
          end
        end
        SC_NEWLEN: begin
          if (b < NEW_LEN_TWO_BYTE) begin
            hit = header_end({24'd0, b});
          end else if (b < NEW_LEN_PARTIAL) begin
            first_len = b;
            scan_phase = SC_NEWLEN2;
          end else if (b == NEW_LEN_FIVE_BYTE) begin
            len_left = 3'd4;
            len_acc = 32'd0;
            scan_phase = SC_BYTES;
          end else begin
            hit = scan_fail();
          end
        end
        SC_NEWLEN2: begin
          hit = header_end((({24'd0, first_len} - 32'd192) << 8) + {24'd0, b} + 32'd192);
        end
        SC_BYTES: begin
          len_acc = {len_acc[23:0], b};
          len_left = len_left - 3'd1;
          if (len_left == 3'd0) hit = header_end(len_acc);
        end
        SC_SKIP: begin
          skip_left = skip_left - 32'd1;
          if (skip_left == 32'd0) scan_phase = SC_HEADER;
        end
        default: begin
          scan_phase = SC_HEADER;
        end
      endcase
    end
    if (byte_pos != 32'hFFFF_FFFF) byte_pos = byte_pos + 32'd1;
    if (lst) begin
      if (!hit && !done_flag) begin
        if (scan_phase == SC_NEWLEN || scan_phase == SC_NEWLEN2 || scan_phase == SC_BYTES)
          push_status(ST_MALFORMED);
        else
          push_status(ST_NOTFOUND);
      end
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'd0;
      in_last <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = byte_queue.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= next_beat.data;
        in_last <= next_beat.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      model_tag = WANTED_TAG_RESET;
    end else begin
      if (cfg_valid && cfg_ready) model_tag = cfg_wanted_tag;
      if (in_valid && in_ready) scan_byte(in_data_byte, in_last);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: status %0d offset %0h length %0h total %0h",
                     out_status, out_payload_offset, out_payload_length,
                     out_total_consumed);
        end else begin
          got_result = pending_results.pop_front();
          if (out_status !== got_result.status ||
              out_payload_offset !== got_result.offset ||
              out_payload_length !== got_result.length ||
              out_total_consumed !== got_result.total) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %0d/%0h/%0h/%0h got %0d/%0h/%0h/%0h",
                       got_result.status, got_result.offset, got_result.length,
                       got_result.total, out_status, out_payload_offset,
                       out_payload_length, out_total_consumed);
          end
        end
      end
    end
  end

  task automatic flush_stream();
    for (int i = 0; i < stream_buf.size(); i++)
      byte_queue.push_back({stream_buf[i], i == stream_buf.size() - 1});
    bytes_queued += stream_buf.size();
    stream_buf.delete();
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_tag(input logic [5:0] t);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_wanted_tag <= t;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_want = t;
  endtask

  task automatic put_header(input logic nf, input logic [5:0] tg, input logic [31:0] len);
    logic [31:0] l2;
    logic [1:0]  lt;
    int          nb;
    if (nf) begin
      stream_buf.push_back({2'b11, tg});
      if (len < 32'd192 && $urandom_range(3) != 0) begin
        stream_buf.push_back(len[7:0]);
      end else if (len >= 32'd192 && len <= 32'd8383 && $urandom_range(3) != 0) begin
        l2 = len - 32'd192;
        stream_buf.push_back(NEW_LEN_TWO_BYTE + l2[15:8]);
        stream_buf.push_back(l2[7:0]);
      end else begin
        stream_buf.push_back(NEW_LEN_FIVE_BYTE);
        for (int i = 3; i >= 0; i--) stream_buf.push_back(len[8*i +: 8]);
      end
    end else begin
      if (len < 32'd256) begin
        case ($urandom_range(2))
          0: lt = OLD_LEN_ONE;
          1: lt = OLD_LEN_TWO;
          default: lt = OLD_LEN_FOUR;
        endcase
      end else if (len < 32'd65536) begin
        lt = $urandom_range(1) ? OLD_LEN_TWO : OLD_LEN_FOUR;
      end else begin
        lt = OLD_LEN_FOUR;
      end
      nb = (lt == OLD_LEN_ONE) ? 1 : (lt == OLD_LEN_TWO) ? 2 : 4;
      stream_buf.push_back({2'b10, tg[3:0], lt});
      for (int i = nb - 1; i >= 0; i--) stream_buf.push_back(len[8*i +: 8]);
    end
  endtask

  task automatic random_stream();
    int          npk;
    int          roll;
    int          cut;
    logic        nf;
    logic [5:0]  tg;
    logic [31:0] ln;
    logic        stop;
    stream_buf.delete();
    stop = 1'b0;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) stream_buf.push_back(8'($urandom_range(255)));
    end else begin
      npk = $urandom_range(1, 4);
      for (int k = 0; k < npk && !stop; k++) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          case ($urandom_range(2))
            0: stream_buf.push_back(8'($urandom_range(127)));
            1: stream_buf.push_back({2'b10, 4'($urandom_range(15)), OLD_LEN_INDET});
            default: begin
              stream_buf.push_back({2'b11, 6'($urandom_range(63))});
              stream_buf.push_back(8'($urandom_range(224, 254)));
            end
          endcase
          stop = 1'b1;
        end else if (roll < 38) begin
          nf = (cur_want > 6'd15) ? 1'b1 : 1'($urandom_range(1));
          case ($urandom_range(4))
            0: ln = $urandom_range(191);
            1: ln = $urandom_range(8383);
            2: ln = $urandom;
            3: ln = 32'hFFFF_FFFF;
            default: ln = 32'd0;
          endcase
          put_header(nf, cur_want, ln);
          repeat ($urandom_range(0, 3)) stream_buf.push_back(8'($urandom_range(255)));
          stop = 1'b1;
        end else begin
          nf = 1'($urandom_range(1));
          do tg = nf ? 6'($urandom_range(63)) : 6'($urandom_range(15));
          while (tg == cur_want);
          ln = ($urandom_range(29) == 0) ? $urandom_range(192, 260) : $urandom_range(12);
          put_header(nf, tg, ln);
          repeat (ln) stream_buf.push_back(8'($urandom_range(255)));
        end
      end
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 3)) stream_buf.push_back(8'($urandom_range(255)));
      if ($urandom_range(6) == 0 && stream_buf.size() > 1) begin
        cut = $urandom_range(1, stream_buf.size() - 1);
        while (stream_buf.size() > cut) void'(stream_buf.pop_back());
      end
    end
    flush_stream();
  endtask

  initial begin
    logic [5:0] plan_tag;
    int         start;
    logic       paused;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed streams under the reset tag.
    stream_buf = '{8'h00, 8'hFF};
    flush_stream();
    stream_buf = '{8'hBF};
    flush_stream();
    stream_buf = '{8'hC2, 8'hFE};
    flush_stream();
    stream_buf = '{8'hC1, 8'hBF};
    flush_stream();
    stream_buf = '{8'h86, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    flush_stream();
    stream_buf = '{8'hC2, 8'h02, 8'hAA, 8'h55};
    flush_stream();
    stream_buf = '{8'h80, 8'h00, 8'h81};
    flush_stream();
    stream_buf = '{8'hC1, 8'hDF, 8'hFF};
    flush_stream();

    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      case (p)
        0: plan_tag = 6'd0;
        1: plan_tag = 6'd63;
        2: plan_tag = 6'd15;
        3, 6: plan_tag = 6'($urandom_range(63));
        default: plan_tag = 6'($urandom_range(15));
      endcase
      write_tag(plan_tag);
      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      start = bytes_queued;
      paused = 1'b0;
      while (bytes_queued - start < 25) begin
        random_stream();
        if (!paused && bytes_queued - start >= 12) begin
          wait_quiet();
          paused = 1'b1;
        end
      end
    end

    wait_quiet();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
